>>> rtl/core/bmh_pkg.sv
// Shared types and constants for the binary max-heap priority queue.
// Holds the request, result and heap entry structs and the controller to datapath codes.
// No dependencies.
package bmh_pkg;

    localparam int CAPACITY_DEFAULT = 1024;
    localparam int KEY_W            = 32;
    localparam int TAG_W            = 16;
    localparam int OCC_W            = 11;
    localparam int STATUS_W         = 2;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXTRACTED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] key_in;
        logic [TAG_W-1:0] tag_in;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key_out;
        logic [TAG_W-1:0]    tag_out;
        logic [OCC_W-1:0]    occupancy;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_FIN_FULL,
        OP_FIN_EMPTY,
        OP_UP_READ,
        OP_UP_MOVE,
        OP_UP_PLACE,
        OP_ROOT_READ,
        OP_ROOT_TAKE,
        OP_DN_READ,
        OP_DN_MOVE,
        OP_DN_PLACE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } ctl_t;

    typedef struct packed {
        logic extract_req;
        logic full;
        logic empty;
        logic at_top;
        logic up_swap;
        logic has_child;
        logic dn_swap;
    } sts_t;

endpackage

>>> rtl/core/binary_max_heap_priority_queue.sv
// Top level of the binary max-heap priority queue.
// Instantiates bmh_ctrl and bmh_datapath. Depends on bmh_pkg.
//
// A request is taken on a rising edge where start is high and busy is low. A request
// either inserts a key and tag or extracts the entry with the largest key. Every
// request gives exactly one result, shown on result for one cycle while done is high;
// the receiver cannot hold results off and must take it in that cycle.
// An insert into a full heap is dropped with a full status, and an extract from an
// empty heap gives an empty status.
// The heap lives in a single memory with two registered read ports and one write port.
// Each level of a sift first reads, then compares and writes.
// At the default size the longest request is an insert that climbs ten levels to
// the root.
// Busy is low in the cycle in which done is high, so a new request may be taken at
// the edge that takes the previous result; one request is handled at a time.
// Reset empties the heap and clears done; memory contents are not cleared and are
// never read before they are written.
module binary_max_heap_priority_queue #(
    parameter int CAPACITY = bmh_pkg::CAPACITY_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  bmh_pkg::req_t request,
    output logic          done,
    output bmh_pkg::rsp_t result
);
    import bmh_pkg::*;

    ctl_t ctl;
    sts_t sts;

    bmh_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    bmh_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .ctl     (ctl),
        .sts     (sts),
        .result  (result),
        .done    (done)
    );

endmodule

>>> rtl/core/bmh_datapath.sv
// Datapath of the heap: entry memory with two read ports, count, position and result registers.
// Carries out one operation code per cycle from the controller. Depends on bmh_pkg.
module bmh_datapath #(
    parameter int CAPACITY = bmh_pkg::CAPACITY_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  bmh_pkg::req_t request,
    input  bmh_pkg::ctl_t ctl,
    output bmh_pkg::sts_t sts,
    output bmh_pkg::rsp_t result,
    output logic          done
);
    import bmh_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = CW + 1;

    entry_t mem [CAPACITY];

    entry_t          rd0_reg;
    entry_t          rd1_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            cmd_reg;
    logic            cmd_next;
    logic            done_reg;
    logic            done_next;
    logic [AW-1:0]   pos_reg;
    logic [AW-1:0]   pos_next;
    entry_t          ent_reg;
    entry_t          ent_next;
    rsp_t            result_reg;
    rsp_t            result_next;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    entry_t          wr_data;
    logic [AW-1:0]   rd0_addr;
    logic [AW-1:0]   rd1_addr;

    logic [AW-1:0]   parent;
    logic [IW-1:0]   lc_w;
    logic [IW-1:0]   rc_w;
    logic [CW-1:0]   last_w;
    logic            rc_ok;
    logic            lc_gt;
    logic            rc_gt;
    logic [KEY_W-1:0] best_key;
    entry_t          best_ent;
    logic [IW-1:0]   best_idx;

    assign parent   = AW'((pos_reg - AW'(1)) >> 1);
    assign lc_w     = (IW'(pos_reg) << 1) + IW'(1);
    assign rc_w     = lc_w + IW'(1);
    assign last_w   = count_reg - CW'(1);
    assign rc_ok    = rc_w < IW'(count_reg);
    assign lc_gt    = rd0_reg.key > ent_reg.key;
    assign best_key = lc_gt ? rd0_reg.key : ent_reg.key;
    assign rc_gt    = rc_ok && (rd1_reg.key > best_key);
    assign best_ent = rc_gt ? rd1_reg : rd0_reg;
    assign best_idx = rc_gt ? rc_w : lc_w;

    always_comb
    begin
        sts.extract_req = cmd_reg == CMD_EXTRACT;
        sts.full        = count_reg == CW'(CAPACITY);
        sts.empty       = count_reg == '0;
        sts.at_top      = pos_reg == '0;
        sts.up_swap     = rd0_reg.key < ent_reg.key;
        sts.has_child   = lc_w < IW'(count_reg);
        sts.dn_swap     = lc_gt || rc_gt;
    end

    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = pos_reg;
        wr_data  = ent_reg;
        rd0_addr = '0;
        rd1_addr = '0;
        case (ctl.op)
            OP_UP_READ:
            begin
                rd0_addr = parent;
            end
            OP_UP_MOVE:
            begin
                wr_en   = 1'b1;
                wr_data = rd0_reg;
            end
            OP_UP_PLACE, OP_DN_PLACE:
            begin
                wr_en = 1'b1;
            end
            OP_ROOT_READ:
            begin
                rd1_addr = last_w[AW-1:0];
            end
            OP_DN_READ:
            begin
                rd0_addr = lc_w[AW-1:0];
                rd1_addr = rc_w[AW-1:0];
            end
            OP_DN_MOVE:
            begin
                wr_en   = 1'b1;
                wr_data = best_ent;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd0_reg <= mem[rd0_addr];
        rd1_reg <= mem[rd1_addr];
    end

    always_comb
    begin
        count_next  = count_reg;
        cmd_next    = cmd_reg;
        done_next   = 1'b0;
        pos_next    = pos_reg;
        ent_next    = ent_reg;
        result_next = result_reg;
        case (ctl.op)
            OP_LOAD:
            begin
                cmd_next     = request.command;
                ent_next.key = request.key_in;
                ent_next.tag = request.tag_in;
                pos_next     = count_reg[AW-1:0];
            end
            OP_FIN_FULL:
            begin
                result_next = '{ST_FULL, '0, '0, OCC_W'(count_reg)};
                done_next   = 1'b1;
            end
            OP_FIN_EMPTY:
            begin
                result_next = '{ST_EMPTY, '0, '0, OCC_W'(count_reg)};
                done_next   = 1'b1;
            end
            OP_UP_MOVE:
            begin
                pos_next = parent;
            end
            OP_UP_PLACE:
            begin
                count_next  = count_reg + CW'(1);
                result_next = '{ST_INSERTED, '0, '0, OCC_W'(count_reg + CW'(1))};
                done_next   = 1'b1;
            end
            OP_ROOT_TAKE:
            begin
                result_next.key_out = rd0_reg.key;
                result_next.tag_out = rd0_reg.tag;
                ent_next            = rd1_reg;
                count_next          = last_w;
                pos_next            = '0;
            end
            OP_DN_MOVE:
            begin
                pos_next = best_idx[AW-1:0];
            end
            OP_DN_PLACE:
            begin
                result_next.status    = ST_EXTRACTED;
                result_next.occupancy = OCC_W'(count_reg);
                done_next             = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cmd_reg   <= CMD_INSERT;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            cmd_reg   <= cmd_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        ent_reg    <= ent_next;
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

>>> rtl/core/bmh_ctrl.sv
// Controller of the heap: one-hot state machine that sequences loading, sift-up and sift-down.
// Drives operation codes to bmh_datapath and reads its status. Depends on bmh_pkg.
module bmh_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  bmh_pkg::sts_t sts,
    output bmh_pkg::ctl_t ctl,
    output logic          busy
);
    import bmh_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_DISPATCH  = 7'b0000010,
        S_UP_TEST   = 7'b0000100,
        S_UP_STEP   = 7'b0001000,
        S_ROOT_TAKE = 7'b0010000,
        S_DN_TEST   = 7'b0100000,
        S_DN_STEP   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl.op     = OP_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.extract_req)
                begin
                    if (sts.empty)
                    begin
                        ctl.op     = OP_FIN_EMPTY;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctl.op     = OP_ROOT_READ;
                        state_next = S_ROOT_TAKE;
                    end
                end
                else if (sts.full)
                begin
                    ctl.op     = OP_FIN_FULL;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_UP_TEST;
                end
            end
            S_UP_TEST:
            begin
                if (sts.at_top)
                begin
                    ctl.op     = OP_UP_PLACE;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.op     = OP_UP_READ;
                    state_next = S_UP_STEP;
                end
            end
            S_UP_STEP:
            begin
                if (sts.up_swap)
                begin
                    ctl.op     = OP_UP_MOVE;
                    state_next = S_UP_TEST;
                end
                else
                begin
                    ctl.op     = OP_UP_PLACE;
                    state_next = S_IDLE;
                end
            end
            S_ROOT_TAKE:
            begin
                ctl.op     = OP_ROOT_TAKE;
                state_next = S_DN_TEST;
            end
            S_DN_TEST:
            begin
                if (sts.has_child)
                begin
                    ctl.op     = OP_DN_READ;
                    state_next = S_DN_STEP;
                end
                else
                begin
                    ctl.op     = OP_DN_PLACE;
                    state_next = S_IDLE;
                end
            end
            S_DN_STEP:
            begin
                if (sts.dn_swap)
                begin
                    ctl.op     = OP_DN_MOVE;
                    state_next = S_DN_TEST;
                end
                else
                begin
                    ctl.op     = OP_DN_PLACE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != S_IDLE;

endmodule
